@@ design/xmoe_pkg.sv @@
// Package for the x86-64 memory operand encoder: request and result word types,
// error codes and the ModRM/SIB/REX encoding constants. No dependencies.
`timescale 1ns / 1ps

package xmoe_pkg;

  localparam int MAX_OPCODE_BYTES = 3;

  localparam logic [4:0] REG_NONE   = 5'd16;
  localparam logic [4:0] REG_RSP    = 5'd4;
  localparam logic [2:0] RM_SIB     = 3'b100;
  localparam logic [2:0] RM_DISP    = 3'b101;
  localparam logic [3:0] REX_PREFIX = 4'b0100;
  localparam logic [1:0] MOD_MEM    = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP32 = 2'b10;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_EMPTY     = 2'd1;
  localparam logic [1:0] ERR_RSP_INDEX = 2'd2;
  localparam logic [1:0] ERR_SCALE     = 2'd3;

  typedef struct packed {
    logic [2:0]         regop;
    logic               rex_w;
    logic               rex_r;
    logic               rex_force;
    logic               use_label;
    logic [4:0]         base_reg;
    logic [4:0]         idx_reg;
    logic [3:0]         scale;
    logic signed [31:0] disp;
    logic [23:0]        opcode_bytes;
    logic [1:0]         opcode_len;
  } enc_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       reloc;
    logic [1:0] error;
  } enc_res_t;

endpackage

@@ design/x86_memory_operand_encoder.sv @@
// x86-64 memory operand encoder top level: request register, single-pass
// encoder into a byte buffer, and a byte serialiser. Depends on xmoe_pkg.
// Start is taken into the request register; the request is then loaded into the
// byte buffer, which presents the first byte, when the serialiser is idle.
// Throughput: one byte per cycle; a request of n bytes (1 to 7 + MAX_OPCODE_BYTES)
// holds the serialiser until its last byte leaves; a waiting request is loaded
// as that byte leaves, so streams follow one another without a gap. The receiver
// cannot stall. Synchronous active-low reset clears the request flag and serialiser state.
`timescale 1ns / 1ps

module x86_memory_operand_encoder #(
  parameter int MAX_OPCODE_BYTES = xmoe_pkg::MAX_OPCODE_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  xmoe_pkg::enc_req_t in_req,
  output logic              out_valid,
  output xmoe_pkg::enc_res_t out_res
);

  localparam int DEPTH = 7 + MAX_OPCODE_BYTES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int POS_W = $clog2(DEPTH + 1);
  localparam logic [1:0] OPL_MAX = 2'(MAX_OPCODE_BYTES);

  xmoe_pkg::enc_req_t req_r;
  logic               req_vld_r, req_vld_nxt;

  logic                   act_r, act_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       lasti_r, lasti_nxt;
  logic [DEPTH-1:0][7:0]  buf_r, buf_nxt;
  logic [DEPTH-1:0]       rel_r, rel_nxt;
  logic [1:0]             err_r, err_nxt;

  logic buf_free, load, accept, at_last;

  // Encoder signals
  logic       has_base, has_index, dnz, disp_only, inb, need_sib, sib_n;
  logic       disp8, has_disp, rex_x, rex_b, rex_n;
  logic [1:0] ss, mode, opl;
  logic [1:0] err;
  logic [2:0] rm, benc, ifld;
  logic [7:0] rex_byte, modrm, sib;
  logic [2:0] dlen;
  logic [3:0][7:0] opw, dw;
  logic [POS_W-1:0] p_op, p_modrm, p_sib, p_disp, p_end;

  assign at_last  = cnt_r == lasti_r;
  assign buf_free = !act_r || at_last;
  assign load     = req_vld_r && buf_free;
  assign busy     = req_vld_r && !buf_free;
  assign accept   = start && !busy;

  always_comb begin
    has_base  = req_r.base_reg < xmoe_pkg::REG_NONE;
    has_index = req_r.idx_reg < xmoe_pkg::REG_NONE;
    dnz       = req_r.disp != 32'sd0;
    disp_only = !has_base && !has_index;
    inb       = !has_base && has_index;
    disp8     = (req_r.disp[31:7] == '0) || (req_r.disp[31:7] == '1);

    ss  = 2'd0;
    err = xmoe_pkg::ERR_NONE;
    if (disp_only && !dnz) begin
      err = xmoe_pkg::ERR_EMPTY;
    end else if (has_index && req_r.idx_reg == xmoe_pkg::REG_RSP) begin
      err = xmoe_pkg::ERR_RSP_INDEX;
    end else if (has_index) begin
      case (req_r.scale)
        4'd1: ss = 2'd0;
        4'd2: ss = 2'd1;
        4'd4: ss = 2'd2;
        4'd8: ss = 2'd3;
        default: err = xmoe_pkg::ERR_SCALE;
      endcase
    end

    benc     = has_base ? req_r.base_reg[2:0] : xmoe_pkg::RM_DISP;
    need_sib = (has_base && req_r.base_reg[2:0] == xmoe_pkg::RM_SIB) || has_index;
    sib_n    = need_sib || disp_only;
    has_disp = dnz || (has_base && req_r.base_reg[2:0] == xmoe_pkg::RM_DISP) || inb;
    rex_b    = has_base && req_r.base_reg[3];
    rex_x    = has_index && req_r.idx_reg[3];
    ifld     = has_index ? req_r.idx_reg[2:0] : xmoe_pkg::RM_SIB;
    rm       = sib_n ? xmoe_pkg::RM_SIB : benc;

    if (disp_only || inb) begin
      mode = xmoe_pkg::MOD_MEM;
      dlen = 3'd4;
    end else if (has_disp) begin
      mode = disp8 ? xmoe_pkg::MOD_DISP8 : xmoe_pkg::MOD_DISP32;
      dlen = disp8 ? 3'd1 : 3'd4;
    end else begin
      mode = xmoe_pkg::MOD_MEM;
      dlen = 3'd0;
    end
    sib   = {ss, ifld, benc};
    modrm = {mode, req_r.regop, rm};
    dw    = req_r.disp;

    if (req_r.use_label) begin
      rex_x = 1'b0;
      rex_b = 1'b0;
      sib_n = 1'b0;
      dlen  = 3'd4;
      modrm = {xmoe_pkg::MOD_MEM, req_r.regop, xmoe_pkg::RM_DISP};
      dw    = '0;
      err   = xmoe_pkg::ERR_NONE;
    end

    rex_n    = req_r.rex_force || req_r.rex_w || req_r.rex_r || rex_x || rex_b;
    rex_byte = {xmoe_pkg::REX_PREFIX, req_r.rex_w, req_r.rex_r, rex_x, rex_b};

    opl = req_r.opcode_len;
    if (opl == 2'd0) begin
      opl = 2'd1;
    end
    if (opl > OPL_MAX) begin
      opl = OPL_MAX;
    end
    opw = {8'h00, req_r.opcode_bytes};

    p_op    = POS_W'(rex_n);
    p_modrm = p_op + POS_W'(opl);
    p_sib   = p_modrm + POS_W'(1);
    p_disp  = p_sib + POS_W'(sib_n);
    p_end   = p_disp + POS_W'(dlen) - POS_W'(1);
  end

  always_comb begin
    buf_nxt   = buf_r;
    rel_nxt   = rel_r;
    lasti_nxt = lasti_r;
    err_nxt   = err_r;
    if (load) begin
      err_nxt = err;
      for (int i = 0; i < DEPTH; i++) begin
        rel_nxt[i] = 1'b0;
        if (POS_W'(i) < p_op) begin
          buf_nxt[i] = rex_byte;
        end else if (POS_W'(i) < p_modrm) begin
          buf_nxt[i] = opw[2'(POS_W'(i) - p_op)];
        end else if (POS_W'(i) == p_modrm) begin
          buf_nxt[i] = modrm;
        end else if (sib_n && POS_W'(i) == p_sib) begin
          buf_nxt[i] = sib;
        end else begin
          buf_nxt[i] = dw[2'(POS_W'(i) - p_disp)];
          rel_nxt[i] = req_r.use_label;
        end
      end
      lasti_nxt = IDX_W'(p_end);
      if (err != xmoe_pkg::ERR_NONE) begin
        buf_nxt[0] = 8'h00;
        rel_nxt[0] = 1'b0;
        lasti_nxt  = '0;
      end
    end
  end

  always_comb begin
    req_vld_nxt = req_vld_r;
    if (accept) begin
      req_vld_nxt = 1'b1;
    end else if (load) begin
      req_vld_nxt = 1'b0;
    end
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (load) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (act_r) begin
      act_nxt = !at_last;
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      act_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      req_vld_r <= req_vld_nxt;
      act_r     <= act_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    buf_r   <= buf_nxt;
    rel_r   <= rel_nxt;
    lasti_r <= lasti_nxt;
    err_r   <= err_nxt;
  end

  assign out_valid        = act_r;
  assign out_res.out_byte = buf_r[cnt_r];
  assign out_res.last     = at_last;
  assign out_res.reloc    = rel_r[cnt_r];
  assign out_res.error    = err_r;

endmodule
